// ===== rtl/core/lirks_pkg.sv =====
`default_nettype none

package lirks_pkg;

  localparam int TABLE_SLOTS = 25;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int FRAME_BITS  = 32;
  localparam int COUNT_W     = $clog2(FRAME_BITS);
  localparam int STEP_W      = 4;
  localparam int POS_W       = 7;
  // Wide enough for slot * step and for the 7-bit position with headroom.
  localparam int TGT_W       = (SLOT_W + STEP_W > POS_W + 1) ? SLOT_W + STEP_W : POS_W + 1;

  localparam logic [7:0]       BYTE_ALL_ONES = 8'hFF;
  localparam logic [POS_W-1:0] PULSE_MAX     = 7'd127;

  localparam logic [7:0]       RST_ZERO_MIN   = 8'd8;
  localparam logic [7:0]       RST_ZERO_LIMIT = 8'd15;
  localparam logic [7:0]       RST_ONE_MIN    = 8'd18;
  localparam logic [7:0]       RST_ONE_LIMIT  = 8'd25;
  localparam logic [STEP_W-1:0] RST_STEP      = 4'd4;
  localparam logic [POS_W-1:0] RST_POS_MAX    = 7'd99;

  typedef logic [2:0] status_t;
  localparam status_t STATUS_BROKEN  = 3'd0;
  localparam status_t STATUS_LEARNED = 3'd1;
  localparam status_t STATUS_FULL    = 3'd2;
  localparam status_t STATUS_MOVED   = 3'd3;
  localparam status_t STATUS_TEACH   = 3'd4;

  typedef enum logic [2:0] {
    REG_ZERO_MIN,
    REG_ZERO_LIMIT,
    REG_ONE_MIN,
    REG_ONE_LIMIT,
    REG_STEP_PER_SLOT,
    REG_POSITION_MAX
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_MOVE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/learned_ir_key_stepper.sv =====
// An item that needs no table search is taken and its result, if any, is registered at the
// same edge. A frame that ends in work mode scans slots 1 and up through the table's single
// read port, one slot per cycle with each compare in the cycle after its read, then passes
// through the multiply state and the move state.
// Throughput: one item per cycle outside a search; no item is taken while a result waits.
// Reset: synchronous, active high; clears the frame, enters teach mode at slot 1, zeroes the
// position and loads the default windows and limits. The key table holds until written.
`default_nettype none

module learned_ir_key_stepper (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [7:0]  interval_ticks,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  address,
  output logic [7:0]  key_code,
  output logic [4:0]  slot_found,
  output logic        move_up,
  output logic [6:0]  pulse_count,
  output logic [6:0]  position,
  output logic [4:0]  learn_slot,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  localparam int SW = lirks_pkg::SLOT_W;
  localparam int TW = lirks_pkg::TGT_W;
  localparam int PW = lirks_pkg::POS_W;
  localparam int CW = lirks_pkg::COUNT_W;

  localparam logic [SW-1:0] SLOT_FIRST = SW'(1);
  localparam logic [SW-1:0] SLOT_LAST  = SW'(lirks_pkg::TABLE_SLOTS - 1);

  lirks_pkg::state_t state, state_next;

  // Configuration registers.
  logic [7:0]    zero_min, zero_limit, one_min, one_limit;
  logic [lirks_pkg::STEP_W-1:0] step_per_slot;
  logic [PW-1:0] position_max;

  // Frame and mode state.
  logic                        in_frame;
  logic [CW-1:0]               bit_count;
  logic [lirks_pkg::FRAME_BITS-2:0] bit_shift;
  logic                        last_bit;
  logic                        teaching;
  logic [SW-1:0]               teach_slot;
  logic [PW-1:0]               tracked_position;

  // Key table and search.
  logic [15:0]   key_table [lirks_pkg::TABLE_SLOTS];
  logic [15:0]   rd_data;
  logic [15:0]   search_key;
  logic [SW-1:0] scan_idx;
  logic          issue_en;
  logic          cmp_valid;
  logic [SW-1:0] cmp_idx;
  logic [SW-1:0] hit_slot;
  logic [TW-1:0] target;

  logic          in_fire;
  logic          bit_zero, bit_one, new_bit;
  logic          frame_end, edge_item, ends_frame;
  logic [lirks_pkg::FRAME_BITS-1:0] frame_word;
  logic [7:0]    word_addr, word_code, word_chk;
  logic          word_broken;
  logic [SW:0]   teach_next;
  logic          table_full;
  logic          start_scan;
  logic          key_match, scan_done;

  logic [TW-1:0] pos_ext;
  logic [TW-1:0] up_diff, down_diff;
  logic          go_up, go_down;
  logic [PW-1:0] up_pulses, up_pos, move_pos;

  logic          out_load;
  lirks_pkg::status_t status_next;
  logic [7:0]    address_next, key_code_next;
  logic [4:0]    slot_found_next, learn_slot_next;
  logic          move_up_next;
  logic [PW-1:0] pulse_count_next;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid & in_ready;

  // Bit classing; the zero window wins where the windows overlap.
  assign bit_zero = (interval_ticks >= zero_min) && (interval_ticks < zero_limit);
  assign bit_one  = (interval_ticks >= one_min) && (interval_ticks < one_limit);
  assign new_bit  = bit_zero ? 1'b0 : (bit_one ? 1'b1 : last_bit);

  assign frame_end  = bit_count == CW'(lirks_pkg::FRAME_BITS - 1);
  assign edge_item  = !command && !frame_start && in_frame;
  assign ends_frame = edge_item && frame_end;

  assign frame_word  = {new_bit, bit_shift};
  assign word_addr   = frame_word[7:0];
  assign word_code   = frame_word[23:16];
  assign word_chk    = frame_word[31:24];
  assign word_broken = ((word_code | word_chk) != lirks_pkg::BYTE_ALL_ONES) ||
                       (word_code == lirks_pkg::BYTE_ALL_ONES);

  assign teach_next = {1'b0, teach_slot} + (SW + 1)'(1);
  assign table_full = teach_next == (SW + 1)'(lirks_pkg::TABLE_SLOTS);

  assign start_scan = in_fire && ends_frame && !word_broken && !teaching;

  assign key_match = rd_data == search_key;
  assign scan_done = cmp_valid && (key_match || cmp_idx == SLOT_LAST);

  // Move arithmetic on the registered target.
  assign pos_ext   = TW'(tracked_position);
  assign go_up     = target > pos_ext;
  assign go_down   = target < pos_ext;
  assign up_diff   = target - pos_ext;
  assign down_diff = pos_ext - target;
  assign up_pulses = (up_diff > TW'(lirks_pkg::PULSE_MAX)) ? lirks_pkg::PULSE_MAX
                                                           : up_diff[PW-1:0];
  assign up_pos    = (target > TW'(position_max)) ? position_max : target[PW-1:0];
  assign move_pos  = go_up ? up_pos : (go_down ? target[PW-1:0] : tracked_position);

  // Sequencer: next state.
  always_comb begin
    state_next = state;
    case (state)
      lirks_pkg::ST_IDLE: if (start_scan) state_next = lirks_pkg::ST_SCAN;
      lirks_pkg::ST_SCAN: if (scan_done) state_next = lirks_pkg::ST_MUL;
      lirks_pkg::ST_MUL:  state_next = lirks_pkg::ST_MOVE;
      lirks_pkg::ST_MOVE: state_next = lirks_pkg::ST_IDLE;
      default:            state_next = lirks_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs.
  always_comb begin
    in_ready = 1'b0;
    case (state)
      lirks_pkg::ST_IDLE: in_ready = !out_valid || out_ready;
      default:            in_ready = 1'b0;
    endcase
  end

  // Result selection.
  always_comb begin
    out_load         = 1'b0;
    status_next      = lirks_pkg::STATUS_BROKEN;
    address_next     = word_addr;
    key_code_next    = word_code;
    slot_found_next  = 5'd0;
    move_up_next     = 1'b0;
    pulse_count_next = '0;
    learn_slot_next  = 5'(teach_slot);
    if (state == lirks_pkg::ST_MOVE) begin
      out_load         = 1'b1;
      status_next      = lirks_pkg::STATUS_MOVED;
      address_next     = search_key[7:0];
      key_code_next    = search_key[15:8];
      slot_found_next  = 5'(hit_slot);
      move_up_next     = go_up;
      pulse_count_next = go_up ? up_pulses : (go_down ? down_diff[PW-1:0] : '0);
    end else if (in_fire && command) begin
      out_load        = !teaching;
      status_next     = lirks_pkg::STATUS_TEACH;
      address_next    = 8'd0;
      key_code_next   = 8'd0;
      learn_slot_next = 5'(SLOT_FIRST);
    end else if (in_fire && ends_frame) begin
      if (word_broken) begin
        out_load = 1'b1;
      end else if (teaching) begin
        out_load = 1'b1;
        if (table_full) begin
          status_next     = lirks_pkg::STATUS_FULL;
          learn_slot_next = 5'(SLOT_FIRST);
        end else begin
          status_next     = lirks_pkg::STATUS_LEARNED;
          learn_slot_next = 5'(teach_next);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= lirks_pkg::ST_IDLE;
      zero_min         <= lirks_pkg::RST_ZERO_MIN;
      zero_limit       <= lirks_pkg::RST_ZERO_LIMIT;
      one_min          <= lirks_pkg::RST_ONE_MIN;
      one_limit        <= lirks_pkg::RST_ONE_LIMIT;
      step_per_slot    <= lirks_pkg::RST_STEP;
      position_max     <= lirks_pkg::RST_POS_MAX;
      in_frame         <= 1'b0;
      bit_count        <= '0;
      bit_shift        <= '0;
      last_bit         <= 1'b0;
      teaching         <= 1'b1;
      teach_slot       <= SLOT_FIRST;
      tracked_position <= '0;
      out_valid        <= 1'b0;
      issue_en         <= 1'b0;
      cmp_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid) begin
        case (cfg_index)
          lirks_pkg::REG_ZERO_MIN:      zero_min      <= cfg_data;
          lirks_pkg::REG_ZERO_LIMIT:    zero_limit    <= cfg_data;
          lirks_pkg::REG_ONE_MIN:       one_min       <= cfg_data;
          lirks_pkg::REG_ONE_LIMIT:     one_limit     <= cfg_data;
          lirks_pkg::REG_STEP_PER_SLOT: step_per_slot <= cfg_data[lirks_pkg::STEP_W-1:0];
          lirks_pkg::REG_POSITION_MAX:  position_max  <= cfg_data[PW-1:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        if (command) begin
          if (!teaching) begin
            teaching   <= 1'b1;
            teach_slot <= SLOT_FIRST;
          end
        end else if (frame_start) begin
          in_frame  <= 1'b1;
          bit_count <= '0;
          bit_shift <= '0;
          last_bit  <= 1'b0;
        end else if (in_frame) begin
          last_bit <= new_bit;
          if (frame_end) begin
            in_frame  <= 1'b0;
            bit_count <= '0;
            if (!word_broken && teaching) begin
              if (table_full) begin
                teaching   <= 1'b0;
                teach_slot <= SLOT_FIRST;
              end else begin
                teach_slot <= teach_next[SW-1:0];
              end
            end
          end else begin
            bit_count <= bit_count + CW'(1);
            bit_shift <= bit_shift | ((lirks_pkg::FRAME_BITS - 1)'(new_bit) << bit_count);
          end
        end
      end

      // The table is read one slot per cycle; each slot is compared in the cycle after its read.
      if (start_scan) begin
        issue_en  <= 1'b1;
        cmp_valid <= 1'b0;
      end else if (state == lirks_pkg::ST_SCAN) begin
        cmp_valid <= issue_en;
        if (issue_en && scan_idx == SLOT_LAST) issue_en <= 1'b0;
      end

      if (state == lirks_pkg::ST_MOVE) tracked_position <= move_pos;

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Search datapath and result payload.
  always_ff @(posedge clk) begin
    if (start_scan) begin
      search_key <= {word_code, word_addr};
      scan_idx   <= SLOT_FIRST;
    end else if (state == lirks_pkg::ST_SCAN) begin
      cmp_idx <= scan_idx;
      if (issue_en && scan_idx != SLOT_LAST) scan_idx <= scan_idx + SW'(1);
    end
    if (state == lirks_pkg::ST_SCAN && scan_done) begin
      hit_slot <= key_match ? cmp_idx : '0;
    end
    if (state == lirks_pkg::ST_MUL) begin
      target <= TW'(hit_slot) * TW'(step_per_slot);
    end
    if (out_load) begin
      status      <= status_next;
      address     <= address_next;
      key_code    <= key_code_next;
      slot_found  <= slot_found_next;
      move_up     <= move_up_next;
      pulse_count <= pulse_count_next;
      position    <= (state == lirks_pkg::ST_MOVE) ? move_pos : tracked_position;
      learn_slot  <= learn_slot_next;
    end
  end

  // Key table memory: written when a frame is learned, read during the scan.
  always_ff @(posedge clk) begin
    if (in_fire && ends_frame && !word_broken && teaching) begin
      key_table[teach_slot] <= {word_code, word_addr};
    end
    rd_data <= key_table[scan_idx];
  end

endmodule

`default_nettype wire

// ===== rtl/core/lirks_checker.sv =====
`default_nettype none

module lirks_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [7:0] address,
  input logic [7:0] key_code,
  input logic [4:0] slot_found,
  input logic       move_up,
  input logic [6:0] pulse_count,
  input logic [4:0] learn_slot
);

  // A result held back by the consumer keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(address) &&
      $stable(key_code) && $stable(pulse_count) && $stable(learn_slot))
    else $error("result changed while stalled");

  // No new item is taken while an untaken result still occupies the output.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid || out_ready)
    else $error("input taken while output blocked");

  // Only a move carries a slot or pulses.
  a_move_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != lirks_pkg::STATUS_MOVED |->
      slot_found == 5'd0 && pulse_count == 7'd0 && !move_up)
    else $error("non-move result carries move fields");

  // Direction is up only when pulses are issued.
  a_dir_needs_pulses: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_up |-> pulse_count != 7'd0)
    else $error("upward move without pulses");

  // Entering teach mode restarts at the first slot with empty key bytes.
  a_teach_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == lirks_pkg::STATUS_TEACH |->
      learn_slot == 5'd1 && address == 8'd0 && key_code == 8'd0)
    else $error("teach entry result malformed");

endmodule

bind learned_ir_key_stepper lirks_checker u_lirks_checker (.*);

`default_nettype wire

// ===== tb/tb_learned_ir_key_stepper.sv =====
`timescale 1ns / 100ps

module tb_learned_ir_key_stepper;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 400;

  typedef struct packed {
    lirks_pkg::status_t status;
    logic [7:0] address;
    logic [7:0] key_code;
    logic [4:0] slot_found;
    logic       move_up;
    logic [6:0] pulse_count;
    logic [6:0] position;
    logic [4:0] learn_slot;
  } ir_report_t;

  typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC, RX_HOLD} rx_pace_t;

  logic       clk            = 1'b0;
  logic       rst            = 1'b1;
  logic       in_valid       = 1'b0;
  logic       command        = 1'b0;
  logic [7:0] interval_ticks = 8'd0;
  logic       frame_start    = 1'b0;
  logic       out_ready      = 1'b0;
  logic       cfg_valid      = 1'b0;
  logic [2:0] cfg_index      = 3'd0;
  logic [7:0] cfg_data       = 8'd0;

  logic       in_ready;
  logic       out_valid;
  logic       cfg_ready;
  logic [2:0] status;
  logic [7:0] address;
  logic [7:0] key_code;
  logic [4:0] slot_found;
  logic       move_up;
  logic [6:0] pulse_count;
  logic [6:0] position;
  logic [4:0] learn_slot;

  learned_ir_key_stepper DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .interval_ticks(interval_ticks),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .address(address),
    .key_code(key_code),
    .slot_found(slot_found),
    .move_up(move_up),
    .pulse_count(pulse_count),
    .position(position),
    .learn_slot(learn_slot),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Decoder state as the block should hold it.
  int          win0_lo     = 8;
  int          win0_end    = 15;
  int          win1_lo     = 18;
  int          win1_end    = 25;
  int          slot_step   = 4;
  int          pos_ceiling = 99;
  logic [15:0] key_store [lirks_pkg::TABLE_SLOTS];
  logic [31:0] rx_word     = '0;
  int          rx_bits     = 0;
  bit          rx_open     = 1'b0;
  bit          rx_prev     = 1'b0;
  bit          learning    = 1'b1;
  int          learn_idx   = 1;
  int          pos_now     = 0;

  ir_report_t  due_reports [$];
  int          errors       = 0;
  int          items_sent   = 0;
  int          cycles       = 0;
  int          burst_left   = 0;
  bit          gaps_on      = 1'b1;
  rx_pace_t    pace         = RX_OPEN;
  int          pace_left    = 0;

  function automatic bit class_bit(input logic [7:0] t);
    if (t >= win0_lo && t < win0_end) return 1'b0;
    if (t >= win1_lo && t < win1_end) return 1'b1;
    return rx_prev;
  endfunction

  task automatic decode_ir_item(input logic cmd, input logic [7:0] t, input logic start,
                                output bit produced, output ir_report_t rep);
    int         slot;
    int         target;
    int         pulses;
    bit         up;
    bit         b;
    logic [15:0] key;
    produced = 1'b0;
    rep = '0;
    if (cmd) begin
      if (!learning) begin
        learning = 1'b1;
        learn_idx = 1;
        produced = 1'b1;
        rep.status = lirks_pkg::STATUS_TEACH;
      end
    end else if (start) begin
      rx_open = 1'b1;
      rx_bits = 0;
      rx_word = '0;
      rx_prev = 1'b0;
    end else if (rx_open) begin
      b = class_bit(t);
      rx_prev = b;
      rx_word[rx_bits] = b;
      rx_bits++;
      if (rx_bits == 32) begin
        rx_open = 1'b0;
        rx_bits = 0;
        produced = 1'b1;
        rep.address = rx_word[7:0];
        rep.key_code = rx_word[23:16];
        key = {rx_word[23:16], rx_word[7:0]};
        if (((rx_word[23:16] | rx_word[31:24]) != lirks_pkg::BYTE_ALL_ONES) ||
            rx_word[23:16] == lirks_pkg::BYTE_ALL_ONES) begin
          rep.status = lirks_pkg::STATUS_BROKEN;
        end else if (learning) begin
          rep.status = lirks_pkg::STATUS_LEARNED;
          if (learn_idx < lirks_pkg::TABLE_SLOTS) begin
            key_store[learn_idx] = key;
            learn_idx++;
          end
          if (learn_idx >= lirks_pkg::TABLE_SLOTS) begin
            learning = 1'b0;
            learn_idx = 1;
            rep.status = lirks_pkg::STATUS_FULL;
          end
        end else begin
          // Scan downward so that the lowest matching slot is the one kept.
          slot = 0;
          for (int i = lirks_pkg::TABLE_SLOTS - 1; i >= 1; i--) begin
            if (key_store[i] == key) slot = i;
          end
          target = slot * slot_step;
          up = 1'b0;
          pulses = 0;
          if (target > pos_now) begin
            up = 1'b1;
            pulses = target - pos_now;
            if (pulses > int'(lirks_pkg::PULSE_MAX)) pulses = int'(lirks_pkg::PULSE_MAX);
            pos_now = (target > pos_ceiling) ? pos_ceiling : target;
          end else if (target < pos_now) begin
            pulses = pos_now - target;
            pos_now = target;
          end
          rep.status = lirks_pkg::STATUS_MOVED;
          rep.slot_found = 5'(slot);
          rep.move_up = up;
          rep.pulse_count = 7'(pulses);
        end
      end
    end
    rep.position = 7'(pos_now);
    rep.learn_slot = 5'(learn_idx);
  endtask

  // Pick an interval that the current windows class as the wanted bit.
  function automatic logic [7:0] pick_ticks(input bit v);
    logic [7:0] t;
    int         lo;
    int         hi;
    int         k;
    lo = v ? win1_lo : win0_lo;
    hi = v ? win1_end : win0_end;
    for (k = 0; k < 24; k++) begin
      case ($urandom_range(0, 3))
        0, 1: t = (lo < hi) ? 8'($urandom_range(lo, hi - 1)) : 8'($urandom_range(0, 255));
        2: t = 8'($urandom_range(0, 255));
        default: t = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      endcase
      if (class_bit(t) == v) return t;
    end
    for (k = 0; k < 256; k++) begin
      t = 8'(k);
      if (class_bit(t) == v) return t;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [31:0] key_frame(input logic [7:0] addr, input logic [7:0] code);
    logic [7:0] filler;
    logic [7:0] chk;
    filler = 8'($urandom);
    chk = 8'($urandom);
    chk = ~code | (code & chk);
    return {chk, filler, code, addr};
  endfunction

  function automatic logic [31:0] fresh_key_word();
    logic [7:0] addr;
    logic [7:0] code;
    case ($urandom_range(0, 7))
      0: addr = 8'h00;
      1: addr = 8'hFF;
      default: addr = 8'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0: code = 8'h00;
      1: code = 8'hFE;
      default: code = 8'($urandom_range(0, 254));
    endcase
    return key_frame(addr, code);
  endfunction

  function automatic logic [31:0] taught_word(input int s);
    return key_frame(key_store[s][7:0], key_store[s][15:8]);
  endfunction

  function automatic logic [31:0] unknown_key_word();
    logic [7:0] addr;
    logic [7:0] code;
    bit         known;
    do begin
      addr = 8'($urandom);
      code = 8'($urandom_range(0, 254));
      known = 1'b0;
      for (int i = 1; i < lirks_pkg::TABLE_SLOTS; i++) begin
        if (key_store[i] === {code, addr}) known = 1'b1;
      end
    end while (known);
    return key_frame(addr, code);
  endfunction

  // One transfer on the item channel; the sender runs in bursts with gaps between.
  task automatic send_item(input logic cmd, input logic [7:0] ticks, input logic start);
    bit         produced;
    ir_report_t rep;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 6))
          @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    command <= cmd;
    interval_ticks <= ticks;
    frame_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    items_sent++;
    decode_ir_item(cmd, ticks, start, produced, rep);
    if (produced) due_reports.push_back(rep);
  endtask

  // Header plus nbits intervals; a teach request goes in before bit teach_at.
  task automatic send_frame(input logic [31:0] word, input int nbits, input int teach_at);
    int i;
    send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
    for (i = 0; i < nbits; i++) begin
      if (i == teach_at || (learning && $urandom_range(0, 63) == 0))
        send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(1'b0, pick_ticks(word[i]), 1'b0);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input lirks_pkg::cfg_reg_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      lirks_pkg::REG_ZERO_MIN:      win0_lo = int'(val);
      lirks_pkg::REG_ZERO_LIMIT:    win0_end = int'(val);
      lirks_pkg::REG_ONE_MIN:       win1_lo = int'(val);
      lirks_pkg::REG_ONE_LIMIT:     win1_end = int'(val);
      lirks_pkg::REG_STEP_PER_SLOT: slot_step = int'(val[3:0]);
      lirks_pkg::REG_POSITION_MAX:  pos_ceiling = int'(val[6:0]);
      default: ;
    endcase
  endtask

  task automatic write_settings(input int zl, input int ze, input int ol, input int oe,
                                input int st, input int pm);
    settle();
    cfg_put(lirks_pkg::REG_ZERO_MIN, 8'(zl));
    cfg_put(lirks_pkg::REG_ZERO_LIMIT, 8'(ze));
    cfg_put(lirks_pkg::REG_ONE_MIN, 8'(ol));
    cfg_put(lirks_pkg::REG_ONE_LIMIT, 8'(oe));
    cfg_put(lirks_pkg::REG_STEP_PER_SLOT, 8'(st));
    cfg_put(lirks_pkg::REG_POSITION_MAX, 8'(pm));
    cfg_valid <= 1'b0;
  endtask

  task automatic teach_until_full();
    while (learning) begin
      if (learn_idx > 1 && $urandom_range(0, 7) == 0)
        send_frame(taught_word($urandom_range(1, learn_idx - 1)), 32, -1);
      else
        send_frame(fresh_key_word(), 32, -1);
    end
  endtask

  task automatic test_ignored_items();
    write_settings(8, 15, 18, 25, 4, 99);
    send_item(1'b0, 8'd0, 1'b0);
    send_item(1'b0, 8'd255, 1'b0);
    send_item(1'b1, 8'd255, 1'b0);
    send_item(1'b1, 8'd0, 1'b1);
  endtask

  task automatic test_bit_classing();
    logic [7:0]  probe [8];
    logic [31:0] word;
    int          i;
    // Windows overlap on 15..19, where a zero bit must win.
    write_settings(10, 20, 15, 30, 4, 99);
    probe = '{8'd255, 8'd10, 8'd19, 8'd15, 8'd20, 8'd29, 8'd30, 8'd0};
    word = fresh_key_word();
    send_item(1'b0, 8'd0, 1'b1);
    for (i = 0; i < 8; i++) send_item(1'b0, probe[i], 1'b0);
    for (i = 8; i < 32; i++) send_item(1'b0, pick_ticks(word[i]), 1'b0);
  endtask

  task automatic test_broken_frames();
    write_settings(8, 15, 18, 25, 4, 99);
    send_frame({8'hFF, 8'h3C, 8'hFF, 8'h5A}, 32, -1);
    send_frame({8'h00, 8'hC3, 8'h12, 8'hA5}, 32, -1);
  endtask

  task automatic test_frame_restart();
    send_frame(fresh_key_word(), 13, -1);
    send_frame(fresh_key_word(), 32, 5);
  endtask

  task automatic test_fill_table();
    send_frame({8'hFF, 8'h00, 8'h00, 8'h00}, 32, -1);
    send_frame({8'h01, 8'hFF, 8'hFE, 8'hFF}, 32, -1);
    teach_until_full();
  endtask

  task automatic test_moves();
    write_settings(8, 15, 18, 25, 4, 99);
    send_frame(taught_word(5), 32, -1);
    send_frame(taught_word(5), 32, -1);
    send_frame(taught_word(2), 32, -1);
    send_frame(unknown_key_word(), 32, -1);
    write_settings(8, 15, 18, 25, 15, 127);
    send_frame(taught_word(lirks_pkg::TABLE_SLOTS - 1), 32, -1);
    // Lowering the ceiling below the position pulls the next upward move down to it.
    write_settings(8, 15, 18, 25, 15, 10);
    send_frame(taught_word(lirks_pkg::TABLE_SLOTS - 2), 32, -1);
    write_settings(8, 15, 18, 25, 0, 127);
    send_frame(taught_word(7), 32, -1);
    write_settings(8, 15, 18, 25, 9, 0);
    send_frame(taught_word(3), 32, -1);
  endtask

  task automatic test_teach_reentry();
    write_settings(8, 15, 18, 25, 4, 99);
    if (learning) teach_until_full();
    send_frame(taught_word(4), 32, 12);
    send_item(1'b1, 8'd77, 1'b0);
    repeat (2) send_frame(fresh_key_word(), 32, -1);
  endtask

  task automatic random_settings();
    int zl, ze, ol, oe, st, pm;
    case ($urandom_range(0, 5))
      0: begin
        zl = 8; ze = 15; ol = 18; oe = 25;
      end
      1, 2, 3: begin
        zl = $urandom_range(0, 120);
        ze = zl + $urandom_range(1, 40);
        ol = $urandom_range(0, 200);
        oe = ol + $urandom_range(1, 55);
      end
      4: begin
        zl = 0; ze = 128; ol = 128; oe = 255;
      end
      default: begin
        zl = $urandom_range(0, 255);
        ze = $urandom_range(0, 255);
        ol = $urandom_range(0, 255);
        oe = $urandom_range(0, 255);
      end
    endcase
    case ($urandom_range(0, 7))
      0: st = 0;
      1: st = 15;
      default: st = $urandom_range(1, 14);
    endcase
    case ($urandom_range(0, 7))
      0: pm = 0;
      1: pm = 127;
      default: pm = $urandom_range(10, 126);
    endcase
    write_settings(zl, ze, ol, oe, st, pm);
  endtask

  task automatic random_action();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      if (learning) begin
        if ($urandom_range(0, 9) == 0) send_frame($urandom, 32, -1);
        else send_frame(fresh_key_word(), 32, -1);
      end else if ($urandom_range(0, 4) == 0) begin
        send_frame(unknown_key_word(), 32, -1);
      end else begin
        send_frame(taught_word($urandom_range(1, lirks_pkg::TABLE_SLOTS - 1)), 32, -1);
      end
    end else if (pick < 80) begin
      send_frame($urandom, $urandom_range(0, 31), -1);
    end else if (pick < 89) begin
      repeat ($urandom_range(1, 6))
        send_item($urandom_range(0, 31) == 0, 8'($urandom_range(0, 255)),
                  $urandom_range(0, 5) == 0);
    end else if (pick < 90) begin
      send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end else begin
      send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
      repeat (32) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic test_random_traffic();
    int first_items;
    first_items = items_sent;
    while (items_sent - first_items < RANDOM_ITEMS) begin
      random_settings();
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(4, 10))
        if (items_sent - first_items < RANDOM_ITEMS) random_action();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_ignored_items();
    test_bit_classing();
    test_broken_frames();
    test_frame_restart();
    test_fill_table();
    test_moves();
    test_random_traffic();
    test_teach_reentry();
    settle();
    if (errors == 0)
      $display("tb_learned_ir_key_stepper: done, clean");
    else
      $display("tb_learned_ir_key_stepper: done, errors");
    $finish;
  end

  // The receiver switches between stall patterns, including stretches with none.
  always @(posedge clk) begin
    if (pace_left == 0) begin
      pace = rx_pace_t'($urandom_range(0, 4));
      pace_left = (pace == RX_HOLD) ? $urandom_range(5, 30) : $urandom_range(20, 200);
    end
    pace_left--;
    case (pace)
      RX_OPEN:     out_ready <= 1'b1;
      RX_LIGHT:    out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY:    out_ready <= ($urandom_range(0, 3) == 0);
      RX_PERIODIC: out_ready <= (pace_left % 3 != 0);
      default:     out_ready <= 1'b0;
    endcase
  end

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : report_check
    ir_report_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_reports.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, status got %0d", $time, status);
      end else begin
        want = due_reports.pop_front();
        check_field("status", 8'(want.status), 8'(status));
        check_field("address", want.address, address);
        check_field("key_code", want.key_code, key_code);
        check_field("slot_found", 8'(want.slot_found), 8'(slot_found));
        check_field("move_up", 8'(want.move_up), 8'(move_up));
        check_field("pulse_count", 8'(want.pulse_count), 8'(pulse_count));
        check_field("position", 8'(want.position), 8'(position));
        check_field("learn_slot", 8'(want.learn_slot), 8'(learn_slot));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_learned_ir_key_stepper: done, errors");
      $finish;
    end
  end

endmodule
